FILE: rtl/adb_mouse_motion_reporter_top_macros.svh
`ifndef ADB_MOUSE_MOTION_REPORTER_TOP_MACROS_SVH
`define ADB_MOUSE_MOTION_REPORTER_TOP_MACROS_SVH

// concurrent check, quiet while reset is held
`define AMR_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// concurrent check that also holds during reset
`define AMR_CHECK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

FILE: rtl/amr_pkg.sv
package amr_pkg;

    typedef logic [1:0]         t_req;
    typedef logic signed [11:0] t_move;
    typedef logic signed [15:0] t_acc;
    typedef logic [15:0]        t_word;

    localparam t_req REQ_MOVE  = 2'd0;
    localparam t_req REQ_TALK  = 2'd1;
    localparam t_req REQ_DONE  = 2'd2;
    localparam t_req REQ_FLUSH = 2'd3;

    localparam t_word WORD_BASE = 16'h8080;
    localparam t_word WORD_BTN  = 16'h7fff;
    localparam t_word WORD_XMSK = 16'hff80;
    localparam t_word WORD_YMSK = 16'h80ff;

    localparam logic signed [17:0] ACC_MAX  = 18'sd32767;
    localparam logic signed [17:0] ACC_MIN  = -18'sd32768;
    localparam logic signed [15:0] DELTA_MAX = 16'sd63;
    localparam logic signed [15:0] DELTA_MIN = -16'sd63;

endpackage

FILE: rtl/amr_if.sv
interface amr_in_if
    import amr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_req  req_type;
    logic  button_down;
    t_move move_dx;
    t_move move_dy;

    modport source (output valid, req_type, button_down, move_dx, move_dy, input ready);
    modport sink   (input valid, req_type, button_down, move_dx, move_dy, output ready);
endinterface

interface amr_out_if
    import amr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word talk_word;
    logic  talk_has_data;
    logic  change_flag;

    modport source (output valid, talk_word, talk_has_data, change_flag, input ready);
    modport sink   (input valid, talk_word, talk_has_data, change_flag, output ready);
endinterface

FILE: rtl/adb_mouse_motion_reporter_top.sv
// path: each input beat reaches the result beat through the input register, then the result register
// throughput: one beat per cycle; a stalled result register holds back the input register
// state update, saturation, clamp and pack sit between the two registers
// reset: synchronous active-low i_rst_n empties both stages and clears all report state
// flush request clears the same state as reset
module adb_mouse_motion_reporter_top
    import amr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    amr_in_if.sink    i_in,
    amr_out_if.source o_out
);

    `include "adb_mouse_motion_reporter_top_macros.svh"

    logic  r_in_vld;
    t_req  r_req;
    logic  r_btn;
    t_move r_dx;
    t_move r_dy;

    logic  r_cur_btn, n_cur_btn;
    t_acc  r_acc_dx, n_acc_dx;
    t_acc  r_acc_dy, n_acc_dy;
    logic  r_sent_btn, n_sent_btn;
    t_acc  r_sent_dx, n_sent_dx;
    t_acc  r_sent_dy, n_sent_dy;
    logic  r_pend, n_pend;

    logic  r_out_vld;
    t_word r_word, n_word;
    logic  r_has, n_has;

    logic  advance;
    logic signed [17:0] sum_dx, sum_dy, dif_dx, dif_dy;

    function automatic t_acc sat16(input logic signed [17:0] v);
        logic signed [17:0] r;
        r = v;
        if (v > ACC_MAX) r = ACC_MAX;
        if (v < ACC_MIN) r = ACC_MIN;
        return r[15:0];
    endfunction

    function automatic logic [6:0] clamp7(input t_acc v);
        t_acc r;
        r = v;
        if (v > DELTA_MAX) r = DELTA_MAX;
        if (v < DELTA_MIN) r = DELTA_MIN;
        return r[6:0];
    endfunction

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    assign sum_dx = 18'(r_acc_dx) + 18'(r_dx);
    assign sum_dy = 18'(r_acc_dy) + 18'(r_dy);
    assign dif_dx = 18'(r_acc_dx) - 18'(r_sent_dx);
    assign dif_dy = 18'(r_acc_dy) - 18'(r_sent_dy);

    always_comb begin
        n_cur_btn  = r_cur_btn;
        n_acc_dx   = r_acc_dx;
        n_acc_dy   = r_acc_dy;
        n_sent_btn = r_sent_btn;
        n_sent_dx  = r_sent_dx;
        n_sent_dy  = r_sent_dy;
        n_pend     = r_pend;
        n_word     = '0;
        n_has      = 1'b0;
        unique case (r_req)
            REQ_MOVE: begin
                n_cur_btn = r_btn;
                n_acc_dx  = sat16(sum_dx);
                n_acc_dy  = sat16(sum_dy);
                n_pend    = r_pend || (r_cur_btn != r_btn) ||
                            (n_acc_dx != '0) || (n_acc_dy != '0);
            end
            REQ_TALK: begin
                if (r_pend) begin
                    n_sent_btn = r_cur_btn;
                    n_sent_dx  = r_acc_dx;
                    n_sent_dy  = r_acc_dy;
                    n_word     = r_cur_btn ? (WORD_BASE & WORD_BTN) : WORD_BASE;
                    n_word     = (n_word & WORD_XMSK) | {9'd0, clamp7(r_acc_dx)};
                    n_word     = (n_word & WORD_YMSK) | {1'b0, clamp7(r_acc_dy), 8'd0};
                    n_has      = 1'b1;
                end
            end
            REQ_DONE: begin
                n_acc_dx = sat16(dif_dx);
                n_acc_dy = sat16(dif_dy);
                n_pend   = (r_sent_btn != r_cur_btn) || (n_acc_dx != '0) ||
                           (n_acc_dy != '0);
            end
            REQ_FLUSH: begin
                n_cur_btn  = 1'b0;
                n_acc_dx   = '0;
                n_acc_dy   = '0;
                n_sent_btn = 1'b0;
                n_sent_dx  = '0;
                n_sent_dy  = '0;
                n_pend     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_req <= i_in.req_type;
            r_btn <= i_in.button_down;
            r_dx  <= i_in.move_dx;
            r_dy  <= i_in.move_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_btn  <= 1'b0;
            r_acc_dx   <= '0;
            r_acc_dy   <= '0;
            r_sent_btn <= 1'b0;
            r_sent_dx  <= '0;
            r_sent_dy  <= '0;
            r_pend     <= 1'b0;
        end else if (advance) begin
            r_cur_btn  <= n_cur_btn;
            r_acc_dx   <= n_acc_dx;
            r_acc_dy   <= n_acc_dy;
            r_sent_btn <= n_sent_btn;
            r_sent_dx  <= n_sent_dx;
            r_sent_dy  <= n_sent_dy;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (advance) begin
            r_word <= n_word;
            r_has  <= n_has;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.talk_word     = r_word;
    assign o_out.talk_has_data = r_has;
    assign o_out.change_flag   = r_pend;

    // a beat with data implies pending activity and the fixed marker bit
    `AMR_CHECK(a_has_pend, i_clk, i_rst_n, r_out_vld && r_has |-> r_pend && r_word[7])
    // an empty talk result carries no word
    `AMR_CHECK(a_empty_word, i_clk, i_rst_n, r_out_vld && !r_has |-> r_word == '0)
    // flush leaves no pending activity and empty accumulators
    `AMR_CHECK(a_flush_clr, i_clk, i_rst_n,
        advance && r_req == REQ_FLUSH |=> !r_pend && r_acc_dx == '0 && r_acc_dy == '0)
    // a held input beat keeps its contents
    `AMR_CHECK(a_in_hold, i_clk, i_rst_n,
        r_in_vld && !advance |=> r_in_vld && $stable(r_req) && $stable(r_dx))
    // state only moves when the input stage advances
    `AMR_CHECK_ALWAYS(a_state_idle, i_clk,
        i_rst_n && $past(i_rst_n) && !$past(advance) |-> $stable(r_acc_dx) && $stable(r_pend))

endmodule
